FILE: rtl/hdrl_pkg.sv
package hdrl_pkg;

  // input ops
  localparam logic [2:0] OP_HOST_WR = 3'd0;
  localparam logic [2:0] OP_RX_BYTE = 3'd1;
  localparam logic [2:0] OP_MS_TICK = 3'd2;
  localparam logic [2:0] OP_TX_SLOT = 3'd3;
  localparam logic [2:0] OP_TX_DONE = 3'd4;
  localparam logic [2:0] OP_HOST_RD = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_TO_MDM  = 2'd1;
  localparam logic [1:0] KIND_TO_HOST = 2'd2;

  // link phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_RECV = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_END_GAP = 2'd1;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  END_GAP_RST = 8'd20;

  localparam int TX_DEPTH_DEF = 256;
  localparam int RX_DEPTH_DEF = 256;

  localparam int AVAIL_W = 9;

endpackage

FILE: rtl/hdrl_ram.sv
module hdrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/half_duplex_request_reply_link_top.sv
// Path: a request goes from the input register to the result register.
// Throughput: one request per cycle; the block stalls only while the result register is
//   full and the result side stalls.
// Each store read is a registered RAM read of the pointer left by the previous request,
//   with a bypass for a byte written by that request.
// Reset (rst_n low, synchronous): link idle, counters zero, RTS low, isolator enabled,
//   timeout 500 ms, end gap 20 ms. Store contents are not cleared.
module half_duplex_request_reply_link_top
  import hdrl_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [7:0]         in_byte,
  input  logic               in_last,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_write_accepted,
  output logic               out_rts_level,
  output logic               out_opto_level,
  output logic [1:0]         out_link_state,
  output logic [AVAIL_W-1:0] out_rx_available,
  output logic               out_reply_timeout,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // counters hold DEPTH+1 (oversize marker); addresses cover DEPTH
  localparam int TCW = $clog2(TX_DEPTH + 2);
  localparam int RCW = $clog2(RX_DEPTH + 2);
  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RAW = $clog2(RX_DEPTH);
  localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);
  localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);

  // ---------------- input register ----------------
  logic       in_v_r;
  logic [2:0] op_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       adv;

  // request in the input register moves on when the result register is free
  assign adv      = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_op;
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  // ---------------- config ----------------
  logic [15:0] timeout_r;
  logic [7:0]  end_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      end_gap_r <= END_GAP_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end
      if (cfg_index == REG_END_GAP) begin
        end_gap_r <= cfg_data[7:0];
      end
    end
  end

  // ---------------- link state ----------------
  logic [1:0]     phase_r,    phase_nxt;
  logic [TCW-1:0] tx_fill_r,  tx_fill_nxt;
  logic [TCW-1:0] tx_len_r,   tx_len_nxt;
  logic [TCW-1:0] tx_sent_r,  tx_sent_nxt;
  logic [RCW-1:0] rx_fill_r,  rx_fill_nxt;
  logic [RCW-1:0] rx_ready_r, rx_ready_nxt;
  logic [RCW-1:0] rx_pos_r,   rx_pos_nxt;
  logic [15:0]    wait_r,     wait_nxt;
  logic [7:0]     gap_r,      gap_nxt;
  logic           rts_r,      rts_nxt;
  logic           opto_r,     opto_nxt;

  // store ports
  logic           tx_we, rx_we;
  logic [7:0]     tx_rdata, rx_rdata, tx_rd_byte, rx_rd_byte;
  logic [TAW-1:0] tx_raddr;
  logic [RAW-1:0] rx_raddr;
  logic           tx_byp_r, rx_byp_r;
  logic [7:0]     tx_byp_data_r, rx_byp_data_r;

  // result fields
  logic [1:0]     kind;
  logic [7:0]     obyte;
  logic           olast, acc, tmo;
  logic [RCW-1:0] avail;

  assign tx_rd_byte = tx_byp_r ? tx_byp_data_r : tx_rdata;
  assign rx_rd_byte = rx_byp_r ? rx_byp_data_r : rx_rdata;

  always_comb begin
    phase_nxt    = phase_r;
    tx_fill_nxt  = tx_fill_r;
    tx_len_nxt   = tx_len_r;
    tx_sent_nxt  = tx_sent_r;
    rx_fill_nxt  = rx_fill_r;
    rx_ready_nxt = rx_ready_r;
    rx_pos_nxt   = rx_pos_r;
    wait_nxt     = wait_r;
    gap_nxt      = gap_r;
    rts_nxt      = rts_r;
    opto_nxt     = opto_r;
    tx_we        = 1'b0;
    rx_we        = 1'b0;
    kind         = KIND_STATUS;
    obyte        = 8'd0;
    olast        = 1'b0;
    acc          = 1'b0;
    tmo          = 1'b0;

    if (adv) begin
      unique case (op_r)
        OP_HOST_WR: begin
          // refused while a committed request is pending
          if (tx_len_r == '0) begin
            tx_we = (tx_fill_r < TX_FULL);
            if (tx_fill_r <= TX_FULL) begin
              tx_fill_nxt = tx_fill_r + 1'b1;
            end
            if (last_r) begin
              if (tx_we) begin
                tx_len_nxt  = tx_fill_r + 1'b1;
                tx_sent_nxt = '0;
                acc         = 1'b1;
              end
              tx_fill_nxt = '0;
            end else begin
              acc = tx_we;
            end
          end
        end
        OP_RX_BYTE: begin
          if (phase_r == PH_WAIT || phase_r == PH_RECV) begin
            if (rx_fill_r < RX_FULL) begin
              rx_we       = 1'b1;
              rx_fill_nxt = rx_fill_r + 1'b1;
            end
            gap_nxt   = '0;
            phase_nxt = PH_RECV;
            // full buffer ends the reply at once
            if (rx_fill_nxt >= RX_FULL) begin
              rx_ready_nxt = rx_fill_nxt;
              rx_pos_nxt   = '0;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        OP_MS_TICK: begin
          if (phase_r == PH_WAIT) begin
            if (wait_r != 16'hFFFF) begin
              wait_nxt = wait_r + 16'd1;
            end
            if (wait_nxt >= timeout_r) begin
              tmo       = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end else if (phase_r == PH_RECV) begin
            if (gap_r != 8'hFF) begin
              gap_nxt = gap_r + 8'd1;
            end
            if (gap_nxt >= end_gap_r) begin
              rx_ready_nxt = rx_fill_r;
              rx_pos_nxt   = '0;
              phase_nxt    = PH_IDLE;
            end
          end
        end
        OP_TX_SLOT: begin
          if (phase_r == PH_SEND && tx_sent_r < tx_len_r && tx_sent_r < TX_FULL) begin
            kind        = KIND_TO_MDM;
            obyte       = tx_rd_byte;
            tx_sent_nxt = tx_sent_r + 1'b1;
            olast       = (tx_sent_nxt == tx_len_r);
            rts_nxt     = 1'b1;
            opto_nxt    = 1'b0;
          end
        end
        OP_TX_DONE: begin
          // new exchange: drop any unread reply
          if (phase_r == PH_SEND && tx_sent_r >= tx_len_r) begin
            rts_nxt      = 1'b0;
            opto_nxt     = 1'b1;
            tx_len_nxt   = '0;
            tx_sent_nxt  = '0;
            rx_fill_nxt  = '0;
            rx_ready_nxt = '0;
            rx_pos_nxt   = '0;
            wait_nxt     = '0;
            gap_nxt      = '0;
            phase_nxt    = PH_WAIT;
          end
        end
        OP_HOST_RD: begin
          if (rx_pos_r < rx_ready_r && rx_pos_r < RX_FULL) begin
            kind       = KIND_TO_HOST;
            obyte      = rx_rd_byte;
            rx_pos_nxt = rx_pos_r + 1'b1;
            if (rx_pos_nxt == rx_ready_r) begin
              olast        = 1'b1;
              rx_ready_nxt = '0;
              rx_pos_nxt   = '0;
              if (phase_r != PH_RECV) begin
                rx_fill_nxt = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // committed request starts sending as soon as the link is idle
      if (phase_nxt == PH_IDLE && tx_len_nxt != '0) begin
        phase_nxt   = PH_SEND;
        tx_sent_nxt = '0;
      end
    end

    avail = rx_ready_nxt - rx_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tx_fill_r  <= '0;
      tx_len_r   <= '0;
      tx_sent_r  <= '0;
      rx_fill_r  <= '0;
      rx_ready_r <= '0;
      rx_pos_r   <= '0;
      wait_r     <= '0;
      gap_r      <= '0;
      rts_r      <= 1'b0;
      opto_r     <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      tx_fill_r  <= tx_fill_nxt;
      tx_len_r   <= tx_len_nxt;
      tx_sent_r  <= tx_sent_nxt;
      rx_fill_r  <= rx_fill_nxt;
      rx_ready_r <= rx_ready_nxt;
      rx_pos_r   <= rx_pos_nxt;
      wait_r     <= wait_nxt;
      gap_r      <= gap_nxt;
      rts_r      <= rts_nxt;
      opto_r     <= opto_nxt;
    end
  end

  // ---------------- stores ----------------
  // read at the pointer the next request will see; bypass a same-address write
  assign tx_raddr = tx_sent_nxt[TAW-1:0];
  assign rx_raddr = rx_pos_nxt[RAW-1:0];

  hdrl_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_fill_r[TAW-1:0]),
    .wdata(byte_r),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

  hdrl_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_fill_r[RAW-1:0]),
    .wdata(byte_r),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_byp_r <= 1'b0;
      rx_byp_r <= 1'b0;
    end else begin
      tx_byp_r <= tx_we && (tx_fill_r[TAW-1:0] == tx_raddr);
      rx_byp_r <= rx_we && (rx_fill_r[RAW-1:0] == rx_raddr);
    end
  end

  always_ff @(posedge clk) begin
    tx_byp_data_r <= byte_r;
    rx_byp_data_r <= byte_r;
  end

  // ---------------- result register ----------------
  logic               out_v_r;
  logic [1:0]         kind_r;
  logic [7:0]         obyte_r;
  logic               olast_r, acc_r, rts_out_r, opto_out_r, tmo_r;
  logic [1:0]         state_out_r;
  logic [AVAIL_W-1:0] avail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r      <= kind;
      obyte_r     <= obyte;
      olast_r     <= olast;
      acc_r       <= acc;
      rts_out_r   <= rts_nxt;
      opto_out_r  <= opto_nxt;
      state_out_r <= phase_nxt;
      avail_r     <= AVAIL_W'(avail);
      tmo_r       <= tmo;
    end
  end

  assign out_valid          = out_v_r;
  assign out_result_kind    = kind_r;
  assign out_byte           = obyte_r;
  assign out_last           = olast_r;
  assign out_write_accepted = acc_r;
  assign out_rts_level      = rts_out_r;
  assign out_opto_level     = opto_out_r;
  assign out_link_state     = state_out_r;
  assign out_rx_available   = avail_r;
  assign out_reply_timeout  = tmo_r;

endmodule
